// ===== sv/rhp_pkg.sv =====
// Shared types and status codes for the ray to hyperbolic paraboloid intersection block.
package rhp_pkg;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } rhp_ray_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] root_plus;
        logic signed [31:0] root_minus;
        logic               saturated;
    } rhp_hit_t;

    localparam logic [1:0] STAT_HIT   = 2'd0;
    localparam logic [1:0] STAT_NOHIT = 2'd1;
    localparam logic [1:0] STAT_DEGEN = 2'd2;

endpackage

// ===== sv/ray_hyperbolic_paraboloid_hit_top.sv =====
// Ray against x*x - z*z - y = 0: exact quadratic, discriminant, roots, fully pipelined.
// Throughput: one beat per cycle while the output is not stalled; six front stages for the
// coefficients and discriminant, 67 square-root stages (one root bit each), three setup
// stages, 32 divider stages (one quotient bit each, both roots in parallel) and the output
// register.
// Reset clears only the valid bits; the whole pipe holds while the output beat is stalled.
module ray_hyperbolic_paraboloid_hit_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ray_valid,
    output logic             ray_stall,
    input  rhp_pkg::rhp_ray_t ray,
    output logic             hit_valid,
    input  logic             hit_stall,
    output rhp_pkg::rhp_hit_t hit
);
    import rhp_pkg::*;

    localparam int BW   = 66;           // A, B, C signed
    localparam int MW   = 66;           // magnitudes of A, B, C
    localparam int LW   = MW / 3;       // limb width for partial products
    localparam int PW   = 2 * MW;       // B*B and A*C magnitudes
    localparam int DW   = PW + 2;       // discriminant, signed
    localparam int SW   = DW / 2;       // square root bits
    localparam int NW   = SW + 2;       // +-S - B, signed
    localparam int DNW  = BW + 1;       // 2A, signed
    localparam int DVW  = ((NW + FRAC_BITS > DNW + 32) ? NW + FRAC_BITS : DNW + 32) + 1;
    localparam int QB   = 32;

    typedef struct packed {
        logic                 dneg;
        logic                 azero;
        logic signed [BW-1:0] a;
        logic signed [BW-1:0] b;
    } side_t;

    typedef struct packed {
        logic dneg;
        logic azero;
        logic negp;
        logic negm;
        logic ovp;
        logic ovm;
    } dvf_t;

    logic en;
    logic hit_valid_reg;
    assign en        = !hit_valid_reg || !hit_stall;
    assign ray_stall = !en;

    // ---------------- front stages ----------------
    logic signed [63:0] s1_dxdx_reg, s1_dzdz_reg, s1_oxdx_reg, s1_ozdz_reg;
    logic signed [63:0] s1_oxox_reg, s1_ozoz_reg;
    logic signed [31:0] s1_dy_reg, s1_oy_reg;
    logic signed [BW-1:0] s2_a_reg, s2_b_reg, s2_c_reg;
    logic [MW-1:0] s3_am_reg, s3_bm_reg, s3_cm_reg;
    logic          s3_acneg_reg;
    side_t         s3_side_reg;
    logic [2*LW-1:0] s4_pbb_reg [0:8];
    logic [2*LW-1:0] s4_pac_reg [0:8];
    logic [2*LW-1:0] pbb_next [0:8];
    logic [2*LW-1:0] pac_next [0:8];
    logic          s4_acneg_reg;
    side_t         s4_side_reg;
    logic [PW-1:0] s5_bb_reg, s5_ac_reg, bb_next, ac_next;
    logic          s5_acneg_reg;
    side_t         s5_side_reg;
    logic [DW-1:0] d_next;
    logic [DW-1:0] s6_d_reg;
    side_t         s6_side_reg;
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pbb_next[3*i+j] = s3_bm_reg[LW*i +: LW] * s3_bm_reg[LW*j +: LW];
                pac_next[3*i+j] = s3_am_reg[LW*i +: LW] * s3_cm_reg[LW*j +: LW];
            end
        end
    end

    always_comb
    begin
        bb_next = '0;
        ac_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                bb_next = bb_next + (PW'(s4_pbb_reg[3*i+j]) << (LW*(i+j)));
                ac_next = ac_next + (PW'(s4_pac_reg[3*i+j]) << (LW*(i+j)));
            end
        end
    end

    always_comb
    begin
        if (s5_acneg_reg)
            d_next = {2'b00, s5_bb_reg} + {s5_ac_reg, 2'b00};
        else
            d_next = {2'b00, s5_bb_reg} - {s5_ac_reg, 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dxdx_reg <= ray.dir_x * ray.dir_x;
            s1_dzdz_reg <= ray.dir_z * ray.dir_z;
            s1_oxdx_reg <= ray.origin_x * ray.dir_x;
            s1_ozdz_reg <= ray.origin_z * ray.dir_z;
            s1_oxox_reg <= ray.origin_x * ray.origin_x;
            s1_ozoz_reg <= ray.origin_z * ray.origin_z;
            s1_dy_reg   <= ray.dir_y;
            s1_oy_reg   <= ray.origin_y;

            s2_a_reg <= BW'(s1_dxdx_reg) - BW'(s1_dzdz_reg);
            s2_b_reg <= ((BW'(s1_oxdx_reg) - BW'(s1_ozdz_reg)) <<< 1)
                        - (BW'(s1_dy_reg) <<< FRAC_BITS);
            s2_c_reg <= BW'(s1_oxox_reg) - BW'(s1_ozoz_reg) - (BW'(s1_oy_reg) <<< FRAC_BITS);

            s3_am_reg    <= s2_a_reg[BW-1] ? MW'(-s2_a_reg) : MW'(s2_a_reg);
            s3_bm_reg    <= s2_b_reg[BW-1] ? MW'(-s2_b_reg) : MW'(s2_b_reg);
            s3_cm_reg    <= s2_c_reg[BW-1] ? MW'(-s2_c_reg) : MW'(s2_c_reg);
            s3_acneg_reg <= s2_a_reg[BW-1] ^ s2_c_reg[BW-1];
            s3_side_reg  <= '{dneg: 1'b0, azero: (s2_a_reg == '0), a: s2_a_reg, b: s2_b_reg};

            s4_pbb_reg   <= pbb_next;
            s4_pac_reg   <= pac_next;
            s4_acneg_reg <= s3_acneg_reg;
            s4_side_reg  <= s3_side_reg;

            s5_bb_reg    <= bb_next;
            s5_ac_reg    <= ac_next;
            s5_acneg_reg <= s4_acneg_reg;
            s5_side_reg  <= s4_side_reg;

            // A negative discriminant feeds zero into the root so the pipe stays well defined.
            s6_d_reg    <= d_next[DW-1] ? '0 : d_next;
            s6_side_reg <= '{dneg: d_next[DW-1], azero: s5_side_reg.azero,
                             a: s5_side_reg.a, b: s5_side_reg.b};
        end
    end

    // ---------------- square root, one bit per stage ----------------
    logic [DW-1:0] sq_rem_reg [0:SW-1];
    logic [SW-1:0] sq_res_reg [0:SW-1];
    side_t         sq_side_reg [0:SW-1];
    logic [DW-1:0] sq_rem_next [0:SW-1];
    logic [SW-1:0] sq_res_next [0:SW-1];
    side_t         sq_side_next [0:SW-1];
    logic [SW-1:0] sq_v_reg;

    always_comb
    begin : sq_comb
        int            k;
        logic [DW-1:0] rem_in;
        logic [SW-1:0] res_in;
        logic [DW-1:0] trial;
        for (int g = 0; g < SW; g++)
        begin
            k = SW - 1 - g;
            if (g == 0)
            begin
                rem_in          = s6_d_reg;
                res_in          = '0;
                sq_side_next[g] = s6_side_reg;
            end
            else
            begin
                rem_in          = sq_rem_reg[(g == 0) ? 0 : g - 1];
                res_in          = sq_res_reg[(g == 0) ? 0 : g - 1];
                sq_side_next[g] = sq_side_reg[(g == 0) ? 0 : g - 1];
            end
            trial = (DW'(res_in) << (k + 1)) | (DW'(1'b1) << (2 * k));
            if (rem_in >= trial)
            begin
                sq_rem_next[g] = rem_in - trial;
                sq_res_next[g] = res_in | (SW'(1'b1) << k);
            end
            else
            begin
                sq_rem_next[g] = rem_in;
                sq_res_next[g] = res_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rem_reg  <= sq_rem_next;
            sq_res_reg  <= sq_res_next;
            sq_side_reg <= sq_side_next;
        end
    end

    // ---------------- numerator and denominator setup ----------------
    logic signed [NW-1:0]  n1_np_reg, n1_nm_reg;
    logic signed [DNW-1:0] n1_den_reg;
    logic                  n1_dneg_reg, n1_azero_reg;
    logic [NW-1:0]         abs_p_next, abs_m_next;
    logic [DVW-1:0]        n2_nmp_reg, n2_nmm_reg, n3_nmp_reg, n3_nmm_reg;
    logic [DNW-1:0]        n2_dm_reg, n3_dm_reg;
    dvf_t                  n2_f_reg, n3_f_reg;
    logic n1_v_reg, n2_v_reg, n3_v_reg;

    assign abs_p_next = n1_np_reg[NW-1] ? NW'(-n1_np_reg) : NW'(n1_np_reg);
    assign abs_m_next = n1_nm_reg[NW-1] ? NW'(-n1_nm_reg) : NW'(n1_nm_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_np_reg    <= $signed({2'b00, sq_res_reg[SW-1]}) - NW'(sq_side_reg[SW-1].b);
            n1_nm_reg    <= -$signed({2'b00, sq_res_reg[SW-1]}) - NW'(sq_side_reg[SW-1].b);
            n1_den_reg   <= {sq_side_reg[SW-1].a, 1'b0};
            n1_dneg_reg  <= sq_side_reg[SW-1].dneg;
            n1_azero_reg <= sq_side_reg[SW-1].azero;

            n2_nmp_reg <= DVW'(abs_p_next) << FRAC_BITS;
            n2_nmm_reg <= DVW'(abs_m_next) << FRAC_BITS;
            n2_dm_reg  <= n1_den_reg[DNW-1] ? DNW'(-n1_den_reg) : DNW'(n1_den_reg);
            n2_f_reg   <= '{dneg: n1_dneg_reg, azero: n1_azero_reg,
                            negp: n1_np_reg[NW-1] ^ n1_den_reg[DNW-1],
                            negm: n1_nm_reg[NW-1] ^ n1_den_reg[DNW-1],
                            ovp: 1'b0, ovm: 1'b0};

            // A quotient of 2^32 or more always clamps, so the divider needs only 32 bits.
            n3_nmp_reg <= n2_nmp_reg;
            n3_nmm_reg <= n2_nmm_reg;
            n3_dm_reg  <= n2_dm_reg;
            n3_f_reg   <= '{dneg: n2_f_reg.dneg, azero: n2_f_reg.azero,
                            negp: n2_f_reg.negp, negm: n2_f_reg.negm,
                            ovp: n2_nmp_reg >= (DVW'(n2_dm_reg) << QB),
                            ovm: n2_nmm_reg >= (DVW'(n2_dm_reg) << QB)};
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    logic [DVW-1:0] dv_rp_reg [0:QB-1];
    logic [DVW-1:0] dv_rm_reg [0:QB-1];
    logic [QB-1:0]  dv_qp_reg [0:QB-1];
    logic [QB-1:0]  dv_qm_reg [0:QB-1];
    logic [DNW-1:0] dv_dm_reg [0:QB-1];
    dvf_t           dv_f_reg  [0:QB-1];
    logic [DVW-1:0] dv_rp_next [0:QB-1];
    logic [DVW-1:0] dv_rm_next [0:QB-1];
    logic [QB-1:0]  dv_qp_next [0:QB-1];
    logic [QB-1:0]  dv_qm_next [0:QB-1];
    logic [DNW-1:0] dv_dm_next [0:QB-1];
    dvf_t           dv_f_next  [0:QB-1];
    logic [QB-1:0]  dv_v_reg;

    always_comb
    begin : dv_comb
        int             i;
        logic [DVW-1:0] rp_in, rm_in, sub;
        logic [QB-1:0]  qp_in, qm_in;
        for (int g = 0; g < QB; g++)
        begin
            i = QB - 1 - g;
            if (g == 0)
            begin
                rp_in         = n3_nmp_reg;
                rm_in         = n3_nmm_reg;
                qp_in         = '0;
                qm_in         = '0;
                dv_dm_next[g] = n3_dm_reg;
                dv_f_next[g]  = n3_f_reg;
            end
            else
            begin
                rp_in         = dv_rp_reg[(g == 0) ? 0 : g - 1];
                rm_in         = dv_rm_reg[(g == 0) ? 0 : g - 1];
                qp_in         = dv_qp_reg[(g == 0) ? 0 : g - 1];
                qm_in         = dv_qm_reg[(g == 0) ? 0 : g - 1];
                dv_dm_next[g] = dv_dm_reg[(g == 0) ? 0 : g - 1];
                dv_f_next[g]  = dv_f_reg[(g == 0) ? 0 : g - 1];
            end
            sub = DVW'(dv_dm_next[g]) << i;
            if (rp_in >= sub)
            begin
                dv_rp_next[g] = rp_in - sub;
                dv_qp_next[g] = qp_in | (QB'(1'b1) << i);
            end
            else
            begin
                dv_rp_next[g] = rp_in;
                dv_qp_next[g] = qp_in;
            end
            if (rm_in >= sub)
            begin
                dv_rm_next[g] = rm_in - sub;
                dv_qm_next[g] = qm_in | (QB'(1'b1) << i);
            end
            else
            begin
                dv_rm_next[g] = rm_in;
                dv_qm_next[g] = qm_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rp_reg <= dv_rp_next;
            dv_rm_reg <= dv_rm_next;
            dv_qp_reg <= dv_qp_next;
            dv_qm_reg <= dv_qm_next;
            dv_dm_reg <= dv_dm_next;
            dv_f_reg  <= dv_f_next;
        end
    end

    // ---------------- sign, clamp and status ----------------
    function automatic logic [32:0] fix_root(input logic neg, input logic ov,
                                             input logic [31:0] q);
        logic [32:0] r;
        if (neg)
        begin
            if (ov || q > 32'h8000_0000)
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, 32'(-q)};
        end
        else
        begin
            if (ov || q > 32'h7FFF_FFFF)
                r = {1'b1, 32'h7FFF_FFFF};
            else
                r = {1'b0, q};
        end
        return r;
    endfunction

    logic [32:0] rp_next, rm_next;
    rhp_hit_t    hit_next, hit_reg;
    dvf_t        fl;

    assign fl      = dv_f_reg[QB-1];
    assign rp_next = fix_root(fl.negp, fl.ovp, dv_qp_reg[QB-1]);
    assign rm_next = fix_root(fl.negm, fl.ovm, dv_qm_reg[QB-1]);

    always_comb
    begin
        hit_next = '0;
        if (fl.dneg)
            hit_next.status = STAT_NOHIT;
        else if (fl.azero)
            hit_next.status = STAT_DEGEN;
        else
        begin
            hit_next.status     = STAT_HIT;
            hit_next.root_plus  = rp_next[31:0];
            hit_next.root_minus = rm_next[31:0];
            hit_next.saturated  = rp_next[32] | rm_next[32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            hit_reg <= hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            s6_v_reg      <= 1'b0;
            sq_v_reg      <= '0;
            n1_v_reg      <= 1'b0;
            n2_v_reg      <= 1'b0;
            n3_v_reg      <= 1'b0;
            dv_v_reg      <= '0;
            hit_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg      <= ray_valid;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg;
            s5_v_reg      <= s4_v_reg;
            s6_v_reg      <= s5_v_reg;
            sq_v_reg      <= {sq_v_reg[SW-2:0], s6_v_reg};
            n1_v_reg      <= sq_v_reg[SW-1];
            n2_v_reg      <= n1_v_reg;
            n3_v_reg      <= n2_v_reg;
            dv_v_reg      <= {dv_v_reg[QB-2:0], n3_v_reg};
            hit_valid_reg <= dv_v_reg[QB-1];
        end
    end

    assign hit_valid = hit_valid_reg;
    assign hit       = hit_reg;

endmodule

// ===== verif/ray_hyperbolic_paraboloid_hit_top_tb.sv =====
// Self-checking testbench for the ray to hyperbolic paraboloid intersection block.
`timescale 1ns / 1ps

module ray_hyperbolic_paraboloid_hit_top_tb;
    import rhp_pkg::*;

    localparam int FRAC = 16;
    localparam int PHASE_ITEMS = 545;
    localparam int DRAIN_CYCLES = 150;

    typedef logic signed [255:0] wide_s_t;
    typedef logic [255:0]        wide_u_t;

    logic      clk;
    logic      rst_n;
    logic      ray_valid;
    logic      ray_stall;
    rhp_ray_t  ray;
    logic      hit_valid;
    logic      hit_stall;
    rhp_hit_t  hit;

    rhp_ray_t  pending_rays[$];
    rhp_hit_t  expected_hits[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        rays_sent;
    int        hits_checked;
    int        mismatches;
    int        orphan_hits;
    int        hit_count;
    int        miss_count;
    int        degen_count;
    int        sat_count;

    ray_hyperbolic_paraboloid_hit_top #(.FRAC_BITS(FRAC)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray_valid (ray_valid),
        .ray_stall (ray_stall),
        .ray       (ray),
        .hit_valid (hit_valid),
        .hit_stall (hit_stall),
        .hit       (hit)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Divide one root numerator by 2A, truncating toward zero, then clamp to 32 bits.
    function automatic logic signed [31:0] clamp_quotient(input wide_s_t num, input wide_s_t den,
                                                          inout logic sat);
        logic    neg;
        wide_u_t q;
        neg = num[255] ^ den[255];
        q = wide_u_t'(num[255] ? -num : num) / wide_u_t'(den[255] ? -den : den);
        if (neg)
        begin
            if (q > wide_u_t'(64'h8000_0000))
            begin
                sat = 1'b1;
                return 32'sh8000_0000;
            end
            return -$signed(q[31:0]);
        end
        if (q > wide_u_t'(64'h7FFF_FFFF))
        begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        return $signed(q[31:0]);
    endfunction

    function automatic rhp_hit_t predict_hit(input rhp_ray_t r);
        wide_s_t  ox, oy, oz, dx, dy, dz, one;
        wide_s_t  qa, qb, qc, disc, num;
        wide_u_t  root_d, cand;
        rhp_hit_t h;
        logic     sat;
        ox = r.origin_x;
        oy = r.origin_y;
        oz = r.origin_z;
        dx = r.dir_x;
        dy = r.dir_y;
        dz = r.dir_z;
        one = wide_s_t'(1) <<< FRAC;
        qa = dx * dx - dz * dz;
        qb = 2 * (ox * dx - oz * dz) - dy * one;
        qc = ox * ox - oz * oz - oy * one;
        disc = qb * qb - 4 * qa * qc;
        h = '0;
        sat = 1'b0;
        if (disc < 0)
        begin
            h.status = STAT_NOHIT;
            return h;
        end
        if (qa == 0)
        begin
            h.status = STAT_DEGEN;
            return h;
        end
        root_d = '0;
        for (int k = 127; k >= 0; k--)
        begin
            cand = root_d | (wide_u_t'(1) << k);
            if (cand * cand <= wide_u_t'(disc))
                root_d = cand;
        end
        h.status = STAT_HIT;
        num = ($signed(root_d) - qb) * one;
        h.root_plus = clamp_quotient(num, 2 * qa, sat);
        num = (-$signed(root_d) - qb) * one;
        h.root_minus = clamp_quotient(num, 2 * qa, sat);
        h.saturated = sat;
        return h;
    endfunction

    function automatic logic [31:0] small_fix();
        return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    function automatic rhp_ray_t random_ray();
        rhp_ray_t r;
        int       kind;
        kind = $urandom_range(0, 9);
        if (kind < 3)
        begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        else
        begin
            r.origin_x = small_fix();
            r.origin_y = small_fix();
            r.origin_z = small_fix();
            r.dir_x = small_fix();
            r.dir_y = small_fix();
            r.dir_z = small_fix();
            // Equal |dx| and |dz| make the leading coefficient vanish.
            if (kind == 3)
                r.dir_z = $urandom_range(0, 1) ? r.dir_x : -r.dir_x;
            // Tiny x and z directions against a distant y origin push the roots out of range.
            if (kind == 4)
            begin
                r.dir_x = $urandom_range(0, 3) - 1;
                r.dir_z = $urandom_range(0, 3) - 1;
                r.origin_y = $urandom;
            end
        end
        return r;
    endfunction

    // Sender: holds a stalled beat, otherwise offers the next ray or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_valid <= 1'b0;
            ray <= '0;
        end
        else
        begin
            if (ray_valid && !ray_stall)
            begin
                expected_hits.push_back(predict_hit(ray));
                rays_sent++;
            end
            if (!ray_valid || !ray_stall)
            begin
                if (pending_rays.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    ray <= pending_rays.pop_front();
                    ray_valid <= 1'b1;
                end
                else
                begin
                    ray_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall and field-by-field comparison of every hit beat.
    always @(posedge clk or negedge rst_n)
    begin
        rhp_hit_t want;
        if (!rst_n)
        begin
            hit_stall <= 1'b0;
        end
        else
        begin
            hit_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            if (hit_valid && !hit_stall)
            begin
                if (expected_hits.size() == 0)
                begin
                    orphan_hits++;
                    if (mismatches + orphan_hits <= 10)
                        $display("ERROR: unexpected hit beat %p", hit);
                end
                else
                begin
                    want = expected_hits.pop_front();
                    hits_checked++;
                    case (want.status)
                        STAT_HIT:   hit_count++;
                        STAT_NOHIT: miss_count++;
                        default:    degen_count++;
                    endcase
                    if (want.saturated)
                        sat_count++;
                    if (hit.status !== want.status || hit.root_plus !== want.root_plus
                        || hit.root_minus !== want.root_minus
                        || hit.saturated !== want.saturated)
                    begin
                        mismatches++;
                        if (mismatches + orphan_hits <= 10)
                            $display("ERROR: beat %0d expected %p got %p",
                                     hits_checked, want, hit);
                    end
                end
            end
        end
    end

    initial
    begin
        rhp_ray_t r;
        send_idle_pct = 17;
        recv_idle_pct = 85;
        rays_sent = 0;
        hits_checked = 0;
        mismatches = 0;
        orphan_hits = 0;
        hit_count = 0;
        miss_count = 0;
        degen_count = 0;
        sat_count = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rays: zero, extremes, a clean two-root hit, a miss, clamping.
        pending_rays.push_back('0);
        pending_rays.push_back({6{32'h8000_0000}});
        pending_rays.push_back({6{32'h7FFF_FFFF}});
        pending_rays.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000});
        pending_rays.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001});
        pending_rays.push_back({32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0});
        pending_rays.push_back({32'h0, 32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0});
        pending_rays.push_back({32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000});
        pending_rays.push_back({32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001, 32'h0, 32'h0});
        pending_rays.push_back({32'h0, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0});
        pending_rays.push_back({32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
                                32'h0001_0000});
        pending_rays.push_back({32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                                32'hFFFF_0000});
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 17;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                r = random_ray();
                pending_rays.push_back(r);
            end
            while (pending_rays.size() > 0 || ray_valid || expected_hits.size() > 0)
                @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d rays, checked %0d: %0d hits, %0d misses, %0d degenerate, %0d clamped.",
                 rays_sent, hits_checked, hit_count, miss_count, degen_count, sat_count);
        $display("Mismatches %0d, unexpected beats %0d, across three stall patterns.",
                 mismatches, orphan_hits);
        if (mismatches == 0 && orphan_hits == 0 && expected_hits.size() == 0)
            $display("** ray_hyperbolic_paraboloid_hit_top: PASSED **");
        else
            $display("** ray_hyperbolic_paraboloid_hit_top: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("ERROR: timeout with %0d hits outstanding", expected_hits.size());
        $display("** ray_hyperbolic_paraboloid_hit_top: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
sv/rhp_pkg.sv
sv/ray_hyperbolic_paraboloid_hit_top.sv
verif/ray_hyperbolic_paraboloid_hit_top_tb.sv
